### hw/rtl/u8u16_pkg.sv
// Shared types, constants and decode helpers for the UTF-8 to UTF-16 stream converter.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

	localparam logic [15:0] UNIT_REPL = 16'hFFFD;
	localparam logic [15:0] SUR_HI_BASE = 16'hD800;
	localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
	localparam logic [20:0] CP_SUPP = 21'h10000;
	localparam logic [9:0] LOW10_MASK = 10'h3FF;
	localparam logic [4:0] LEAD4_PAT = 5'h1E;
	localparam logic [3:0] LEAD3_PAT = 4'hE;
	localparam logic [2:0] LEAD2_PAT = 3'h6;
	localparam logic [5:0] MAX_UNITS_RST = 6'd62;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Units produced by one input byte, before the unit limit is applied.
	typedef struct packed {
		logic [2:0][15:0] units;
		logic [1:0] n_units;
		logic pair;
		logic last;
	} u8u16_item_t;

	// Continuation bytes a lead asks for; zero for ASCII and stray bytes.
	function automatic logic [1:0] conts_needed(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if (b[7:5] == LEAD2_PAT) n = 2'd1;
		else if (b[7:4] == LEAD3_PAT) n = 2'd2;
		else if (b[7:3] == LEAD4_PAT) n = 2'd3;
		return n;
	endfunction

	// A byte decoded on its own: ASCII passes, anything else is the replacement.
	function automatic logic [15:0] byte_unit(input logic [7:0] b);
		return b[7] ? UNIT_REPL : {8'h00, b};
	endfunction

endpackage

`default_nettype wire

### hw/rtl/u8u16_front.sv
// Front end: gathers multi-byte sequences and turns each byte into a list of code units.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front
	import u8u16_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [7:0] in_byte,
	input wire logic end_of_string,
	output u8u16_item_t item
);

	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;

	logic [7:0] nh [3];
	logic [1:0] nhc;
	logic [1:0] need_h;
	logic f_emit;
	logic [20:0] f_cp;
	logic [20:0] sup_v;

	always_comb begin
		nh = held_q;
		nhc = held_cnt_q;
		need_h = conts_needed(held_q[0]);
		f_emit = 1'b0;
		f_cp = '0;
		if (held_cnt_q == 2'd0) begin
			if (conts_needed(in_byte) == 2'd0) begin
				f_emit = 1'b1;
				f_cp = {5'b0, byte_unit(in_byte)};
			end else begin
				nh[0] = in_byte;
				nhc = 2'd1;
			end
		end else if (held_cnt_q == need_h) begin
			f_emit = 1'b1;
			nhc = 2'd0;
			unique case (need_h)
				2'd1: f_cp = {10'b0, held_q[0][4:0], in_byte[5:0]};
				2'd2: f_cp = {5'b0, held_q[0][3:0], held_q[1][5:0], in_byte[5:0]};
				default: f_cp = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], in_byte[5:0]};
			endcase
		end else begin
			nh[held_cnt_q] = in_byte;
			nhc = held_cnt_q + 2'd1;
		end
	end

	assign sup_v = f_cp - CP_SUPP;

	always_comb begin
		item = '0;
		item.last = end_of_string;
		if (f_emit) begin
			if (f_cp >= CP_SUPP) begin
				item.pair = 1'b1;
				item.n_units = 2'd2;
				item.units[0] = SUR_HI_BASE | {5'b0, sup_v[20:10]};
				item.units[1] = SUR_LO_BASE | {6'b0, sup_v[9:0] & LOW10_MASK};
			end else begin
				item.n_units = 2'd1;
				item.units[0] = f_cp[15:0];
			end
		end else if (end_of_string) begin
			// flush: the lead becomes a replacement, the bytes after it decode again
			unique case (nhc)
				2'd1: begin
					item.n_units = 2'd1;
					item.units[0] = UNIT_REPL;
				end
				2'd2: begin
					item.n_units = 2'd2;
					item.units[0] = UNIT_REPL;
					item.units[1] = byte_unit(nh[1]);
				end
				2'd3: begin
					item.units[0] = UNIT_REPL;
					if (conts_needed(nh[1]) == 2'd1) begin
						item.n_units = 2'd2;
						item.units[1] = {5'b0, nh[1][4:0], nh[2][5:0]};
					end else begin
						item.n_units = 2'd3;
						item.units[1] = byte_unit(nh[1]);
						item.units[2] = byte_unit(nh[2]);
					end
				end
				default: item.n_units = 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			held_cnt_q <= end_of_string ? 2'd0 : nhc;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= nh;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/u8u16_queue.sv
// Short queue of decoded items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue
	import u8u16_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input u8u16_item_t push_item,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output u8u16_item_t head_item
);

	u8u16_item_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/u8u16_back.sv
// Back end: applies the unit limit, counts units and serializes results to the output.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back
	import u8u16_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [5:0] max_units,
	input wire logic head_valid,
	input u8u16_item_t head_item,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [15:0] code_unit,
	output logic unit_valid,
	output logic string_done,
	output logic [5:0] unit_count
);

	logic busy_q;
	logic [1:0] idx_q;
	logic [1:0] cnt_q;
	logic [2:0][15:0] units_q;
	logic valid_q;
	logic last_q;
	logic [5:0] total_q;
	logic [5:0] em_q;
	logic stop_q;

	logic final_beat;
	logic beat;
	logic [5:0] avail;
	logic [1:0] k;
	logic stop_n;
	logic [5:0] em_n;
	logic [1:0] res_cnt;

	assign final_beat = (idx_q == cnt_q - 2'd1);
	assign beat = busy_q && out_ready;
	assign pop = head_valid && (!busy_q || (beat && final_beat));

	// resolve how many of the head item's units fit under the limit
	always_comb begin
		avail = (max_units > em_q) ? (max_units - em_q) : 6'd0;
		k = 2'd0;
		stop_n = stop_q;
		if (!stop_q) begin
			if (head_item.pair) begin
				if (avail >= 6'd2) k = 2'd2;
				else stop_n = 1'b1;
			end else if ({4'b0, head_item.n_units} <= avail) begin
				k = head_item.n_units;
			end else begin
				k = avail[1:0];
				stop_n = 1'b1;
			end
		end
		em_n = em_q + {4'b0, k};
		res_cnt = (k == 2'd0 && head_item.last) ? 2'd1 : k;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 2'd0;
			cnt_q <= 2'd0;
			last_q <= 1'b0;
			valid_q <= 1'b0;
			em_q <= 6'd0;
			stop_q <= 1'b0;
		end else if (pop) begin
			busy_q <= (res_cnt != 2'd0);
			idx_q <= 2'd0;
			cnt_q <= res_cnt;
			last_q <= head_item.last;
			valid_q <= (k != 2'd0);
			em_q <= head_item.last ? 6'd0 : em_n;
			stop_q <= head_item.last ? 1'b0 : stop_n;
		end else if (beat) begin
			if (final_beat) busy_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			units_q <= head_item.units;
			total_q <= em_n;
		end
	end

	assign out_valid = busy_q;
	assign unit_valid = valid_q;
	assign code_unit = valid_q ? units_q[idx_q] : 16'h0000;
	assign string_done = last_q && final_beat;
	assign unit_count = string_done ? total_q : 6'd0;

endmodule

`default_nettype wire

### hw/rtl/utf8_to_utf16_stream.sv
// Top level of the UTF-8 to UTF-16 stream converter.
// Path: an accepted byte is written to the item queue, then registered in the back end, which drives the output.
// Throughput: one byte per cycle while the item queue is not full; a byte giving two or three results
// holds the output while they are sent, and the two-entry item queue takes up to two more bytes meanwhile.
// Reset (arst_n low, asynchronous): clears held bytes count, unit count, stop flag,
// queue and output; max_units returns to 62.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_stream
	import u8u16_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [5:0] cfg_data,      // max_units
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata,       // [7:0] in_byte
	input wire logic s_tlast,             // end_of_string
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata,          // [15:0] code_unit, [21:16] unit_count, zero pad
	output logic m_tuser,                 // unit_valid
	output logic m_tlast                  // string_done
);

	logic [5:0] max_units_q;
	logic q_full;
	logic accept;
	u8u16_item_t front_item;
	logic head_valid;
	u8u16_item_t head_item;
	logic pop;
	logic [15:0] code_unit;
	logic [5:0] unit_count;

	assign cfg_ready = 1'b1;
	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_units_q <= MAX_UNITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_units_q <= cfg_data;
		end
	end

	u8u16_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_byte(s_tdata),
		.end_of_string(s_tlast),
		.item(front_item)
	);

	u8u16_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_item(front_item),
		.full(q_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_item(head_item)
	);

	u8u16_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.max_units(max_units_q),
		.head_valid(head_valid),
		.head_item(head_item),
		.pop(pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.code_unit(code_unit),
		.unit_valid(m_tuser),
		.string_done(m_tlast),
		.unit_count(unit_count)
	);

	assign m_tdata = {2'b00, unit_count, code_unit};

endmodule

`default_nettype wire
